@@ design/tmt_pkg.sv @@
package tmt_pkg;

    // Field width and range of one distance sample.
    localparam int SAMPLE_W = 11;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 11'd2000;

    // Default batch shape: ten samples, two dropped at each end.
    localparam int SAMPLE_COUNT_DEF = 10;
    localparam int TRIM_EACH_END_DEF = 2;

    // Per-cycle command shared by every cell of the sorting chain.
    typedef struct packed {
        logic insert;   // place the new sample in sorted position
        logic shift;    // move every value one cell toward the head
    } tmt_cell_ctl_t;

endpackage

@@ design/tmt_cell.sv @@
module tmt_cell (
    input  logic                        clk,
    input  tmt_pkg::tmt_cell_ctl_t      ctl,
    input  logic [tmt_pkg::SAMPLE_W-1:0] new_val,
    input  logic                        occupied,
    input  logic [tmt_pkg::SAMPLE_W-1:0] left_val,
    input  logic                        left_lt,
    input  logic [tmt_pkg::SAMPLE_W-1:0] right_val,
    output logic [tmt_pkg::SAMPLE_W-1:0] val,
    output logic                        lt
);
    import tmt_pkg::*;

    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;

    // An empty cell behaves as if it held a value larger than any sample.
    assign lt  = !occupied || (new_val < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert && lt)
        begin
            // Either take the new sample or make room by taking the left value.
            val_next = left_lt ? left_val : new_val;
        end
        else if (ctl.shift)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ design/trimmed_mean_of_ten.sv @@
// Trimmed mean of a batch of distance samples.
//
// Input channel: sample (11 bits, millimetres) with in_valid / in_stall.
// Output channel: mean (11 bits) with out_valid / out_stall. A transaction
// takes place on a rising edge where valid is high and stall is low.
//
// Each sample is clamped to 2000 and inserted into a chain of SAMPLE_COUNT
// sorting cells, so the chain is always in ascending order.
// While a batch fills, one transaction is accepted in every cycle. When the
// last sample of a batch is accepted, in_stall rises and stays high while
// the chain shifts its values out through the head cell one per cycle into
// an accumulator that keeps only the middle values (ST_SUM), the sum is
// multiplied by a fixed reciprocal of the kept count (ST_MUL), and the
// output register is loaded with the mean (ST_OUT).
// The output register holds the result while out_stall is high; the next
// batch may fill meanwhile, and if its result is ready before the old one
// is taken, the block waits with in_stall high until out_stall drops.
// Reset clears the fill count, the state and out_valid; cell contents are
// not cleared since an empty cell is never read.
module trimmed_mean_of_ten #(
    parameter int SAMPLE_COUNT  = tmt_pkg::SAMPLE_COUNT_DEF,
    parameter int TRIM_EACH_END = tmt_pkg::TRIM_EACH_END_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tmt_pkg::SAMPLE_W-1:0] sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tmt_pkg::SAMPLE_W-1:0] mean
);
    import tmt_pkg::*;

    localparam int CNT_W   = $clog2(SAMPLE_COUNT);
    localparam int KEPT    = SAMPLE_COUNT - 2 * TRIM_EACH_END;
    localparam int SUM_W   = $clog2(SAMPLE_COUNT * 2000 + 1);
    // Reciprocal multiply is exact for every sum below 2**SUM_W.
    localparam int SHIFT   = SUM_W + 6;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(KEPT) - 64'd1) / 64'(KEPT));
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLE_COUNT - 1);
    localparam logic [CNT_W-1:0] LO_IDX   = CNT_W'(TRIM_EACH_END);
    localparam logic [CNT_W-1:0] HI_IDX   = CNT_W'(SAMPLE_COUNT - TRIM_EACH_END - 1);

    typedef enum logic [3:0] {
        ST_FILL = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic                out_valid_reg, out_valid_next;
    logic                load_mean;

    logic [SAMPLE_W-1:0] clamped;
    logic                in_take;
    tmt_cell_ctl_t       cell_ctl;

    logic [SAMPLE_W-1:0] cell_val [SAMPLE_COUNT];
    logic                cell_lt  [SAMPLE_COUNT];

    // Out-of-range samples saturate to the ranger's clamp.
    assign clamped  = (sample > SAMPLE_MAX) ? SAMPLE_MAX : sample;
    assign in_stall = (state_reg != ST_FILL);
    assign in_take  = in_valid && !in_stall;

    assign cell_ctl.insert = in_take;
    assign cell_ctl.shift  = (state_reg == ST_SUM);

    // The sorting chain: cell 0 holds the smallest value and is the head.
    for (genvar i = 0; i < SAMPLE_COUNT; i++)
    begin : g_cell
        logic [SAMPLE_W-1:0] l_val;
        logic                l_lt;
        logic [SAMPLE_W-1:0] r_val;

        if (i == 0)
        begin : g_head
            assign l_val = '0;
            assign l_lt  = 1'b0;
        end
        else
        begin : g_body
            assign l_val = cell_val[i-1];
            assign l_lt  = cell_lt[i-1];
        end

        if (i == SAMPLE_COUNT - 1)
        begin : g_tail
            assign r_val = cell_val[i];
        end
        else
        begin : g_inner
            assign r_val = cell_val[i+1];
        end

        tmt_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .new_val   (clamped),
            .occupied  (CNT_W'(i) < count_reg),
            .left_val  (l_val),
            .left_lt   (l_lt),
            .right_val (r_val),
            .val       (cell_val[i]),
            .lt        (cell_lt[i])
        );
    end

    assign load_mean = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (in_take)
                begin
                    if (count_reg == LAST_IDX)
                    begin
                        count_next = '0;
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                // The head cell presents the values in ascending order.
                if (idx_reg >= LO_IDX && idx_reg <= HI_IDX)
                begin
                    acc_next = acc_reg + SUM_W'(cell_val[0]);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_mean)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(RECIP);
        end
        if (load_mean)
        begin
            mean_reg <= prod_reg[SHIFT +: SAMPLE_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;

endmodule

@@ design/tmt_checker.sv @@
module tmt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [tmt_pkg::SAMPLE_W-1:0] mean
);
    import tmt_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean))
        else $error("stalled result changed or dropped");

    // The mean of clamped samples never exceeds the clamp.
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean <= SAMPLE_MAX)
        else $error("mean above sample range");

    // A result is only produced while the input side is held off.
    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while input was open");

endmodule

bind trimmed_mean_of_ten tmt_checker u_tmt_checker (.*);
